[rtl/mmf_pkg.sv]
package mmf_pkg;

    localparam int RING_DEPTH_DEF = 1024;

    typedef enum logic [1:0] {
        REQ_SHORT  = 2'd0,
        REQ_STREAM = 2'd1,
        REQ_READ   = 2'd2
    } req_code_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STAGE,
        S_READ,
        S_DONE
    } mmf_state_t;

    localparam logic [7:0] ST_DATA_MIN = 8'h80;
    localparam logic [7:0] ST_RT_MIN   = 8'hf8;
    localparam logic [7:0] ST_SOX      = 8'hf0;
    localparam logic [7:0] ST_EOX      = 8'hf7;
    localparam logic [7:0] ST_MTC      = 8'hf1;
    localparam logic [7:0] ST_SPP      = 8'hf2;
    localparam logic [7:0] ST_SONG     = 8'hf3;
    localparam logic [7:0] ST_SYS1_MIN = 8'hf4;
    localparam logic [3:0] KIND_PGM    = 4'hc;
    localparam logic [3:0] KIND_CHP    = 4'hd;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [23:0] short_word;
        logic [7:0]  stream_byte;
    } in_t;

    typedef struct packed {
        logic        read_valid;
        logic [7:0]  read_byte;
        logic [9:0]  committed_count;
        logic [31:0] bytes_staged_total;
        logic        sysex_open;
    } out_t;

    // Message length in bytes for a non-realtime status byte
    function automatic logic [1:0] msg_len(input logic [7:0] st);
        logic [1:0] len;
        len = 2'd3;
        if (st[7:4] == KIND_PGM || st[7:4] == KIND_CHP)
            len = 2'd2;
        if (st == ST_MTC || st == ST_SONG)
            len = 2'd2;
        else if (st == ST_SPP)
            len = 2'd3;
        else if (st >= ST_SYS1_MIN)
            len = 2'd1;
        return len;
    endfunction

endpackage

[rtl/midi_message_framing_fifo.sv]
// Channel  Direction  Payload          Handshake
// in       input      mmf_pkg::in_t    in_valid / in_stall
// out      output     mmf_pkg::out_t   out_valid / out_stall
//
// Accept to result: a short message or SysEx byte is staged in S_STAGE, a read fetches in
// S_READ (skipped on an empty ring or an unused code), and S_DONE registers the result;
// the next item is taken back in S_IDLE. One write port paces staging at a byte a cycle.
// Reset clears pointers, flags and the byte total; ring contents are not cleared.
// A new item is taken while a finished result waits in the output register;
// a result stalled at the output holds the next item in its final step.
module midi_message_framing_fifo #(
    parameter int RING_DEPTH = mmf_pkg::RING_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  mmf_pkg::in_t  in_item,
    output logic          out_valid,
    input  logic          out_stall,
    output mmf_pkg::out_t out_item
);
    import mmf_pkg::*;

    localparam int PTR_W = $clog2(RING_DEPTH);

    mmf_state_t state_reg, state_next;

    logic [PTR_W-1:0] stage_ptr_reg, stage_ptr_next;
    logic [PTR_W-1:0] commit_ptr_reg, commit_ptr_next;
    logic [PTR_W-1:0] read_ptr_reg, read_ptr_next;
    logic             sysex_reg, sysex_next;
    logic             overflow_reg, overflow_next;
    logic [31:0]      total_reg, total_next;

    logic [23:0]      word_reg, word_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic [1:0]       idx_reg, idx_next;
    logic             post_fin_reg, post_fin_next;
    logic             hit_reg, hit_next;
    logic [7:0]       rbyte_reg, rbyte_next;

    out_t             out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    logic [7:0]       ring_mem [RING_DEPTH];
    logic [7:0]       rd_data_reg;
    logic             wr_en;
    logic [7:0]       wr_byte;

    logic             accept;
    logic             out_free;
    logic [7:0]       cur_byte;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(RING_DEPTH - 1))
            return '0;
        else
            return p + 1'b1;
    endfunction

    function automatic logic [9:0] ring_count(input logic [PTR_W-1:0] c,
                                              input logic [PTR_W-1:0] r);
        logic [PTR_W:0]    diff;
        logic [PTR_W+10:0] wide;
        if (c >= r)
            diff = {1'b0, c} - {1'b0, r};
        else
            diff = {1'b0, c} + (PTR_W+1)'(RING_DEPTH) - {1'b0, r};
        wide = (PTR_W+11)'(diff);
        return wide[9:0];
    endfunction

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    always_comb
    begin
        case (idx_reg)
            2'd0:    cur_byte = word_reg[7:0];
            2'd1:    cur_byte = word_reg[15:8];
            default: cur_byte = word_reg[23:16];
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_item.req_type)
                        REQ_SHORT, REQ_STREAM: state_next = S_STAGE;
                        REQ_READ:
                        begin
                            if (read_ptr_reg != commit_ptr_reg)
                                state_next = S_READ;
                            else
                                state_next = S_DONE;
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_STAGE:
            begin
                if (idx_reg == cnt_reg)
                    state_next = S_DONE;
            end
            S_READ:  state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        logic [7:0] st;
        logic       act;
        logic       pre_fin;

        st       = in_item.short_word[7:0];
        act      = sysex_reg;
        pre_fin  = 1'b0;

        stage_ptr_next  = stage_ptr_reg;
        commit_ptr_next = commit_ptr_reg;
        read_ptr_next   = read_ptr_reg;
        sysex_next      = sysex_reg;
        overflow_next   = overflow_reg;
        total_next      = total_reg;
        word_next       = word_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        post_fin_next   = post_fin_reg;
        hit_next        = hit_reg;
        rbyte_next      = rbyte_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && out_stall;
        wr_en           = 1'b0;
        wr_byte         = cur_byte;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    word_next     = in_item.short_word;
                    cnt_next      = 2'd0;
                    idx_next      = 2'd0;
                    post_fin_next = 1'b0;
                    hit_next      = 1'b0;
                    rbyte_next    = 8'd0;
                    case (in_item.req_type)
                        REQ_SHORT:
                        begin
                            if (st >= ST_DATA_MIN)
                            begin
                                if (st >= ST_RT_MIN)
                                begin
                                    cnt_next      = 2'd1;
                                    post_fin_next = !sysex_reg;
                                end
                                else
                                begin
                                    pre_fin       = sysex_reg;
                                    sysex_next    = 1'b0;
                                    cnt_next      = msg_len(st);
                                    post_fin_next = 1'b1;
                                end
                            end
                        end
                        REQ_STREAM:
                        begin
                            word_next = {16'd0, in_item.stream_byte};
                            if (in_item.stream_byte == ST_SOX)
                            begin
                                pre_fin = sysex_reg;
                                act     = 1'b1;
                            end
                            if (act)
                            begin
                                cnt_next = 2'd1;
                                if (in_item.stream_byte == ST_EOX)
                                begin
                                    act           = 1'b0;
                                    post_fin_next = 1'b1;
                                end
                            end
                            sysex_next = act;
                        end
                        REQ_READ:  hit_next = (read_ptr_reg != commit_ptr_reg);
                        default:   hit_next = 1'b0;
                    endcase
                    // close the open SysEx before the new message
                    if (pre_fin)
                    begin
                        if (overflow_reg)
                        begin
                            stage_ptr_next = commit_ptr_reg;
                            overflow_next  = 1'b0;
                        end
                        else
                            commit_ptr_next = stage_ptr_reg;
                    end
                end
            end
            S_STAGE:
            begin
                if (idx_reg != cnt_reg)
                begin
                    idx_next = idx_reg + 2'd1;
                    if (!overflow_reg)
                    begin
                        if (ring_next(stage_ptr_reg) == read_ptr_reg)
                            overflow_next = 1'b1;
                        else
                        begin
                            wr_en          = 1'b1;
                            stage_ptr_next = ring_next(stage_ptr_reg);
                            total_next     = total_reg + 32'd1;
                        end
                    end
                end
                else if (post_fin_reg)
                begin
                    if (overflow_reg)
                    begin
                        stage_ptr_next = commit_ptr_reg;
                        overflow_next  = 1'b0;
                    end
                    else
                        commit_ptr_next = stage_ptr_reg;
                end
            end
            S_READ:
            begin
                rbyte_next    = rd_data_reg;
                read_ptr_next = ring_next(read_ptr_reg);
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next              = 1'b1;
                    out_next.read_valid         = hit_reg;
                    out_next.read_byte          = hit_reg ? rbyte_reg : 8'd0;
                    out_next.committed_count    = ring_count(commit_ptr_reg, read_ptr_reg);
                    out_next.bytes_staged_total = total_reg;
                    out_next.sysex_open         = sysex_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            stage_ptr_reg  <= '0;
            commit_ptr_reg <= '0;
            read_ptr_reg   <= '0;
            sysex_reg      <= 1'b0;
            overflow_reg   <= 1'b0;
            total_reg      <= 32'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            stage_ptr_reg  <= stage_ptr_next;
            commit_ptr_reg <= commit_ptr_next;
            read_ptr_reg   <= read_ptr_next;
            sysex_reg      <= sysex_next;
            overflow_reg   <= overflow_next;
            total_reg      <= total_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg     <= word_next;
        cnt_reg      <= cnt_next;
        idx_reg      <= idx_next;
        post_fin_reg <= post_fin_next;
        hit_reg      <= hit_next;
        rbyte_reg    <= rbyte_next;
        out_reg      <= out_next;
    end

    // ring memory: one write port, one registered read port at the read pointer
    always_ff @(posedge clk)
    begin
        if (wr_en)
            ring_mem[stage_ptr_reg] <= wr_byte;
        rd_data_reg <= ring_mem[read_ptr_reg];
    end

endmodule

[test/midi_message_framing_fifo_tb.sv]
`timescale 1ns / 100ps

module testbench;

    import mmf_pkg::*;

    localparam int          DEPTH        = RING_DEPTH_DEF;
    localparam logic [1:0]  REQ_UNUSED   = 2'd3;
    localparam int          IDLE_PCT     = 19;
    localparam int          SETTLE_TICKS = 20;
    localparam int          CYCLE_LIMIT  = 400000;

    class framing_scoreboard;
        logic [7:0]  ring [DEPTH];
        int unsigned stage_ptr;
        int unsigned commit_ptr;
        int unsigned read_ptr;
        bit          sysex_on;
        bit          overflow;
        logic [31:0] staged_total;
        out_t        expected_results[$];
        int          errors;

        function new();
            stage_ptr    = 0;
            commit_ptr   = 0;
            read_ptr     = 0;
            sysex_on     = 0;
            overflow     = 0;
            staged_total = '0;
            errors       = 0;
        endfunction

        function void stage(logic [7:0] b);
            int unsigned nxt;
            if (overflow)
                return;
            nxt = (stage_ptr + 1) % DEPTH;
            // Ring full: poison the rest of this message
            if (nxt == read_ptr) begin
                overflow = 1;
                return;
            end
            ring[stage_ptr] = b;
            stage_ptr = nxt;
            staged_total = staged_total + 32'd1;
        endfunction

        function void commit();
            if (overflow) begin
                stage_ptr = commit_ptr;
                overflow  = 0;
            end
            else
                commit_ptr = stage_ptr;
        endfunction

        function void take_short(logic [23:0] word);
            logic [7:0] status;
            int         msg_bytes;
            status    = word[7:0];
            msg_bytes = 3;
            if (status < ST_DATA_MIN)
                return;
            if (status >= ST_RT_MIN) begin
                // Realtime rides along with an open SysEx
                stage(status);
                if (!sysex_on)
                    commit();
                return;
            end
            if (sysex_on) begin
                sysex_on = 0;
                commit();
            end
            if (status[7:4] == KIND_PGM || status[7:4] == KIND_CHP)
                msg_bytes = 2;
            if (status == ST_MTC || status == ST_SONG)
                msg_bytes = 2;
            else if (status == ST_SPP)
                msg_bytes = 3;
            else if (status >= ST_SYS1_MIN)
                msg_bytes = 1;
            stage(status);
            if (msg_bytes > 1)
                stage(word[15:8]);
            if (msg_bytes > 2)
                stage(word[23:16]);
            commit();
        endfunction

        function void take_stream(logic [7:0] b);
            if (b == ST_SOX) begin
                if (sysex_on)
                    commit();
                sysex_on = 1;
            end
            if (!sysex_on)
                return;
            stage(b);
            if (b == ST_EOX) begin
                sysex_on = 0;
                commit();
            end
        endfunction

        function void note_input(in_t it);
            out_t res;
            res = '0;
            case (it.req_type)
                REQ_SHORT:  take_short(it.short_word);
                REQ_STREAM: take_stream(it.stream_byte);
                REQ_READ:
                    if (read_ptr != commit_ptr) begin
                        res.read_valid = 1'b1;
                        res.read_byte  = ring[read_ptr];
                        read_ptr = (read_ptr + 1) % DEPTH;
                    end
                default: ;
            endcase
            res.committed_count    = 10'((commit_ptr + DEPTH - read_ptr) % DEPTH);
            res.bytes_staged_total = staged_total;
            res.sysex_open         = sysex_on;
            expected_results = {expected_results, res};
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(out_t got);
            out_t want;
            if (expected_results.size() == 0) begin
                report("result arrived with no transfer pending");
                return;
            end
            want = expected_results.pop_front();
            if (got.read_valid !== want.read_valid)
                report($sformatf("read_valid got %0h want %0h",
                                 got.read_valid, want.read_valid));
            if (got.read_byte !== want.read_byte)
                report($sformatf("read_byte got %0h want %0h",
                                 got.read_byte, want.read_byte));
            if (got.committed_count !== want.committed_count)
                report($sformatf("committed_count got %0d want %0d",
                                 got.committed_count, want.committed_count));
            if (got.bytes_staged_total !== want.bytes_staged_total)
                report($sformatf("bytes_staged_total got %0d want %0d",
                                 got.bytes_staged_total, want.bytes_staged_total));
            if (got.sysex_open !== want.sysex_open)
                report($sformatf("sysex_open got %0h want %0h",
                                 got.sysex_open, want.sysex_open));
        endtask
    endclass

    logic  clk = 1'b0;
    logic  rst_n;
    logic  in_valid;
    logic  in_stall;
    in_t   in_item;
    logic  out_valid;
    logic  out_stall;
    out_t  out_item;

    framing_scoreboard sb;
    bit    idle_on;
    int    items_sent;
    int    cycle_count;

    midi_message_framing_fifo DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    always #5 clk = ~clk;

    function automatic in_t make_item(logic [1:0] req, logic [23:0] word, logic [7:0] b);
        in_t it;
        it.req_type    = req;
        it.short_word  = word;
        it.stream_byte = b;
        return it;
    endfunction

    function automatic in_t rand_short();
        logic [7:0] status;
        if ($urandom_range(0, 99) < 5)
            status = 8'($urandom_range(0, 127));
        else
            status = 8'($urandom_range(128, 255));
        return make_item(REQ_SHORT, {16'($urandom), status}, 8'($urandom));
    endfunction

    function automatic in_t rand_stream(logic [7:0] b);
        return make_item(REQ_STREAM, 24'($urandom), b);
    endfunction

    function automatic in_t rand_read();
        return make_item(REQ_READ, 24'($urandom), 8'($urandom));
    endfunction

    // Start a transfer and hold it until taken
    task automatic send(in_t it);
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(it);
        items_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_directed();
        send(rand_read());
        send(make_item(REQ_UNUSED, 24'hffffff, 8'hff));
        send(make_item(REQ_SHORT, 24'hffff7f, 8'h00));
        send(make_item(REQ_SHORT, 24'h7f3c90, 8'h00));
        send(make_item(REQ_SHORT, 24'h0012c5, 8'h00));
        send(make_item(REQ_SHORT, 24'h0040d3, 8'h00));
        send(make_item(REQ_SHORT, 24'h5566f1, 8'h00));
        send(make_item(REQ_SHORT, 24'h3344f2, 8'h00));
        send(make_item(REQ_SHORT, 24'h0009f3, 8'h00));
        send(make_item(REQ_SHORT, 24'hfffff4, 8'h00));
        send(make_item(REQ_SHORT, 24'h1122f6, 8'h00));
        send(make_item(REQ_SHORT, 24'h1122f7, 8'h00));
        send(make_item(REQ_SHORT, 24'h2211f0, 8'h00));
        send(make_item(REQ_SHORT, 24'h0000f8, 8'h00));
        send(make_item(REQ_SHORT, 24'hffffff, 8'hff));
        // Stream byte outside SysEx is dropped
        send(make_item(REQ_STREAM, 24'h000000, 8'h40));
        send(make_item(REQ_STREAM, 24'h000000, ST_SOX));
        send(make_item(REQ_STREAM, 24'h000000, 8'h7e));
        send(make_item(REQ_SHORT, 24'h0000fe, 8'h00));
        send(make_item(REQ_STREAM, 24'h000000, ST_SOX));
        send(make_item(REQ_STREAM, 24'h000000, 8'h01));
        // Channel message closes the SysEx without F7
        send(make_item(REQ_SHORT, 24'h004080, 8'h00));
        send(make_item(REQ_STREAM, 24'h000000, ST_SOX));
        send(make_item(REQ_STREAM, 24'h000000, 8'hff));
        send(make_item(REQ_STREAM, 24'h000000, ST_EOX));
        repeat (4)
            send(rand_read());
    endtask

    task automatic run_random(int n, int read_pct, int short_pct);
        int stop_at;
        int pick;
        int body;
        stop_at = items_sent + n;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < read_pct)
                send(rand_read());
            else if (pick < read_pct + short_pct)
                send(rand_short());
            else if (pick < 95) begin
                send(rand_stream(ST_SOX));
                body = $urandom_range(0, 12);
                repeat (body) begin
                    pick = $urandom_range(0, 99);
                    if (pick < read_pct / 2)
                        send(rand_read());
                    else if (pick < read_pct / 2 + 6)
                        send(make_item(REQ_SHORT, {16'($urandom), 8'($urandom_range(248, 255))},
                                       8'($urandom)));
                    else if (pick < 85)
                        send(rand_stream(8'($urandom_range(0, 127))));
                    else
                        send(rand_stream(8'($urandom)));
                end
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    send(rand_stream(ST_EOX));
                else if (pick < 90)
                    send(rand_short());
                else
                    send(rand_stream(ST_SOX));
            end
            else if (pick < 98)
                send(rand_stream(8'($urandom)));
            else
                send(make_item(REQ_UNUSED, 24'($urandom), 8'($urandom)));
        end
    endtask

    initial begin
        cycle_count = 0;
        while (cycle_count <= CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("testbench failed");
        $finish;
    end

    // Result side: check each transfer, then pick the stall for the next edge
    initial begin
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_result(out_item);
            out_stall <= idle_on && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    initial begin
        sb          = new();
        items_sent  = 0;
        idle_on     = 1'b1;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_item     = '0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        run_random(70, 35, 35);
        idle_on = 1'b0;
        run_random(70, 35, 35);
        idle_on = 1'b1;
        // Fill the ring without reads until messages overflow
        run_random(270, 0, 80);
        wait_drained();
        run_random(50, 90, 5);
        run_random(20, 35, 35);

        wait_drained();
        repeat (SETTLE_TICKS)
            @(posedge clk);
        if (sb.errors == 0 && sb.expected_results.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
